// File: sv/mlnp_pkg.sv
// ----------------------------------------------------------------------------
// mlnp_pkg
// Shared types and constants of the monophonic last-note-priority handler.
// ----------------------------------------------------------------------------
package mlnp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Upper nibble of the MIDI status byte
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CONTROL  = 4'hB;
    localparam logic [3:0] MSG_BEND     = 4'hE;

    localparam logic [6:0] CC_SUSTAIN     = 7'h40;
    localparam logic [6:0] CC_CHANNEL_MIN = 7'h78;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_RESET   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_PUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic needs_scan;
        logic note_on;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// File: sv/mlnp_msg_if.sv
// ----------------------------------------------------------------------------
// mlnp_msg_if
// Input channel: one three-byte MIDI channel message per beat.
// ----------------------------------------------------------------------------
interface mlnp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, output status_byte, output first_data,
                    output second_data, input ready);
    modport sink   (input valid, input status_byte, input first_data,
                    input second_data, output ready);
endinterface

// File: sv/mlnp_evt_if.sv
// ----------------------------------------------------------------------------
// mlnp_evt_if
// Output channel: one voice event per beat.
// ----------------------------------------------------------------------------
interface mlnp_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         voice_action;
    logic [6:0]         action_note;
    logic [6:0]         action_velocity;
    logic               bend_valid;
    logic signed [13:0] bend_amount;
    logic               sounding_valid;
    logic [6:0]         sounding_note;
    logic               sustain_held;

    modport source (output valid, output voice_action, output action_note,
                    output action_velocity, output bend_valid, output bend_amount,
                    output sounding_valid, output sounding_note,
                    output sustain_held, input ready);
    modport sink   (input valid, input voice_action, input action_note,
                    input action_velocity, input bend_valid, input bend_amount,
                    input sounding_valid, input sounding_note,
                    input sustain_held, output ready);
endinterface

// File: sv/mlnp_ctrl.sv
// ----------------------------------------------------------------------------
// mlnp_ctrl
// Sequencer: accepts a message, steps the stack scan and push, then hands the
// event to the output register.
// ----------------------------------------------------------------------------
module mlnp_ctrl
    import mlnp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = i_stat.needs_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = i_stat.note_on ? ST_PUSH : ST_FINISH;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                // Wait here until the previous event has left the output register.
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/mlnp_dp.sv
// ----------------------------------------------------------------------------
// mlnp_dp
// Datapath: message registers, note stack, sounding note, pedal and the
// output event register.
// ----------------------------------------------------------------------------
module mlnp_dp
    import mlnp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [7:0]         i_status_byte,
    input  logic [6:0]         i_first_data,
    input  logic [6:0]         i_second_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_action            o_voice_action,
    output logic [6:0]         o_action_note,
    output logic [6:0]         o_action_velocity,
    output logic               o_bend_valid,
    output logic signed [13:0] o_bend_amount,
    output logic               o_sounding_valid,
    output logic [6:0]         o_sounding_note,
    output logic               o_sustain_held
);

    logic [3:0]       r_nib;
    logic [6:0]       r_d1;
    logic [6:0]       r_d2;
    logic [IDX_W-1:0] r_idx;
    logic [6:0]       r_note [STACK_DEPTH];
    logic             r_vld  [STACK_DEPTH];
    logic             r_act_vld;
    logic [6:0]       r_act_note;
    logic             r_pedal;

    logic             r_out_valid;
    t_action          r_out_action;
    logic [6:0]       r_out_note;
    logic [6:0]       r_out_vel;
    logic             r_out_bend_vld;
    logic [13:0]      r_out_bend;
    logic             r_out_snd_vld;
    logic [6:0]       r_out_snd_note;
    logic             r_out_sustain;

    logic             cur_vld;
    logic             hit;
    logic             at_last;

    logic             n_act_vld;
    logic [6:0]       n_act_note;
    logic             n_pedal;
    logic             clr;
    t_action          action;
    logic [6:0]       vel;
    logic             bend_vld;
    logic [13:0]      bend;
    logic             rel_hit;

    assign cur_vld = r_vld[r_idx];
    assign hit     = cur_vld && (r_note[r_idx] == r_d1);
    assign at_last = (r_idx == IDX_W'(STACK_DEPTH - 1));

    assign o_stat.needs_scan = (r_nib == MSG_NOTE_OFF) || (r_nib == MSG_NOTE_ON);
    assign o_stat.note_on    = (r_nib == MSG_NOTE_ON) && (r_d2 != 7'd0);
    // Valid entries are packed at the front, so the first empty entry ends the scan.
    assign o_stat.scan_last  = hit || at_last || !cur_vld;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign rel_hit = r_act_vld && (r_act_note == r_d1);

    always_comb begin
        n_act_vld  = r_act_vld;
        n_act_note = r_act_note;
        n_pedal    = r_pedal;
        clr        = 1'b0;
        action     = ACT_NONE;
        vel        = 7'd0;
        bend_vld   = 1'b0;
        bend       = 14'd0;
        unique case (r_nib) inside
            MSG_NOTE_OFF, MSG_NOTE_ON: begin
                if (r_nib == MSG_NOTE_ON && r_d2 != 7'd0) begin
                    n_act_vld  = 1'b1;
                    n_act_note = r_d1;
                    action     = ACT_START;
                    vel        = r_d2;
                end else if (rel_hit) begin
                    // The stack has already lost this note; its new front takes over.
                    n_act_vld  = r_vld[0];
                    n_act_note = r_vld[0] ? r_note[0] : 7'd0;
                    if (r_vld[0]) begin
                        action = ACT_RESTART;
                    end else if (!r_pedal) begin
                        action = ACT_STOP;
                    end
                end
            end
            MSG_CONTROL: begin
                if (r_d1 == CC_SUSTAIN) begin
                    n_pedal = r_d2[6];
                    if (!r_d2[6] && !r_act_vld) begin
                        action = ACT_STOP;
                    end
                end else if (r_d1 >= CC_CHANNEL_MIN) begin
                    clr        = 1'b1;
                    n_act_vld  = 1'b0;
                    n_act_note = 7'd0;
                    n_pedal    = 1'b0;
                    action     = ACT_RESET;
                end
            end
            MSG_BEND: begin
                bend_vld = 1'b1;
                // Adding 8192 modulo 2^14 only flips the top bit.
                bend     = {~r_d2[6], r_d2[5:0], r_d1};
            end
            default: begin
                action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STACK_DEPTH; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_idx       <= '0;
            r_act_vld   <= 1'b0;
            r_act_note  <= 7'd0;
            r_pedal     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_nib <= i_status_byte[7:4];
                r_d1  <= i_first_data;
                r_d2  <= i_second_data;
                r_idx <= '0;
            end

            if (i_cmd.scan) begin
                if (hit) begin
                    // Close the gap: every entry from the match onwards moves forward.
                    for (int j = 0; j < STACK_DEPTH - 1; j++) begin
                        if (IDX_W'(j) >= r_idx) begin
                            r_note[j] <= r_note[j + 1];
                            r_vld[j]  <= r_vld[j + 1];
                        end
                    end
                    r_note[STACK_DEPTH - 1] <= 7'd0;
                    r_vld[STACK_DEPTH - 1]  <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            if (i_cmd.push) begin
                for (int j = 1; j < STACK_DEPTH; j++) begin
                    r_note[j] <= r_note[j - 1];
                    r_vld[j]  <= r_vld[j - 1];
                end
                r_note[0] <= r_d1;
                r_vld[0]  <= 1'b1;
            end

            if (i_cmd.finish) begin
                r_act_vld  <= n_act_vld;
                r_act_note <= n_act_note;
                r_pedal    <= n_pedal;
                if (clr) begin
                    for (int j = 0; j < STACK_DEPTH; j++) begin
                        r_vld[j] <= 1'b0;
                    end
                end
                r_out_valid    <= 1'b1;
                r_out_action   <= action;
                r_out_note     <= (action == ACT_START || action == ACT_RESTART) ?
                                  n_act_note : 7'd0;
                r_out_vel      <= vel;
                r_out_bend_vld <= bend_vld;
                r_out_bend     <= bend;
                r_out_snd_vld  <= n_act_vld;
                r_out_snd_note <= n_act_vld ? n_act_note : 7'd0;
                r_out_sustain  <= n_pedal;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_voice_action    = r_out_action;
    assign o_action_note     = r_out_note;
    assign o_action_velocity = r_out_vel;
    assign o_bend_valid      = r_out_bend_vld;
    assign o_bend_amount     = $signed(r_out_bend);
    assign o_sounding_valid  = r_out_snd_vld;
    assign o_sounding_note   = r_out_snd_note;
    assign o_sustain_held    = r_out_sustain;

endmodule

// File: sv/midi_mono_last_note_priority.sv
// ----------------------------------------------------------------------------
// midi_mono_last_note_priority
// Monophonic MIDI note handler with last-note priority and sustain pedal.
// ----------------------------------------------------------------------------
// One event beat is produced for every message beat, in order. From its
// acceptance until the block is ready again, a message passes through the
// dispatch and finish states: note-on and note-off messages walk the held-note
// stack one entry per cycle until the note, the first empty entry or the last
// entry is found, and a note-on with nonzero velocity also pushes the note in front. All
// other messages need no walk. A finished event sits in an output register,
// so the next message is accepted while it waits; only a second finished
// event stalls until the first has been taken.
module midi_mono_last_note_priority
    import mlnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlnp_msg_if.sink   i_msg,
    mlnp_evt_if.source o_evt
);

    t_cmd    cmd;
    t_stat   stat;
    t_action action;

    mlnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .o_in_ready (i_msg.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mlnp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_status_byte     (i_msg.status_byte),
        .i_first_data      (i_msg.first_data),
        .i_second_data     (i_msg.second_data),
        .i_out_ready       (o_evt.ready),
        .o_out_valid       (o_evt.valid),
        .o_voice_action    (action),
        .o_action_note     (o_evt.action_note),
        .o_action_velocity (o_evt.action_velocity),
        .o_bend_valid      (o_evt.bend_valid),
        .o_bend_amount     (o_evt.bend_amount),
        .o_sounding_valid  (o_evt.sounding_valid),
        .o_sounding_note   (o_evt.sounding_note),
        .o_sustain_held    (o_evt.sustain_held)
    );

    assign o_evt.voice_action = action;

    // A start always leaves its own note sounding.
    a_start_sounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && action == ACT_START) |->
        (o_evt.sounding_valid && o_evt.sounding_note == o_evt.action_note))
        else $error("start event does not leave its note sounding");

    a_restart_sounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && action == ACT_RESTART) |->
        (o_evt.sounding_valid && o_evt.sounding_note == o_evt.action_note))
        else $error("restart event does not match the sounding note");

    // A channel reset leaves neither a note nor the pedal behind.
    a_reset_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && action == ACT_RESET) |->
        (!o_evt.sounding_valid && !o_evt.sustain_held))
        else $error("reset event leaves state behind");

    a_bend_no_action : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.bend_valid) |-> (action == ACT_NONE))
        else $error("pitch bend carries a voice action");

endmodule
